### hw/rtl/mpfd_pkg.sv
package mpfd_pkg;

    localparam int NUM_ARQ       = 4;
    localparam int MAX_PDU_BYTES = 256;

    localparam int STREAM_BASE   = 4;
    localparam int STREAM_LAST   = 7;
    localparam int ARQ_DATA_BASE = 8;
    localparam int ARQ_ACK_BASE  = 12;
    localparam int CHANNEL_SHIFT = 3;

    localparam logic [1:0] DEST_STREAM   = 2'd0;
    localparam logic [1:0] DEST_ARQ_DATA = 2'd1;
    localparam logic [1:0] DEST_ARQ_ACK  = 2'd2;

    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_LENGTH  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [8:0] pdu_length;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] dest_kind;
        logic [1:0] channel_index;
        logic [1:0] seq_flags;
        logic       first_of_fragment;
        logic       last_of_fragment;
        logic       empty_fragment;
    } frag_item_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] kind;
        logic [1:0] idx;
        logic [1:0] flags;
    } route_t;

    function automatic route_t route(input logic [7:0] hdr);
        route_t     r;
        logic [4:0] ch;
        ch = 5'(hdr >> CHANNEL_SHIFT);
        r  = '0;
        if (ch >= 5'(STREAM_BASE) && ch <= 5'(STREAM_LAST))
        begin
            r.ok    = 1'b1;
            r.kind  = DEST_STREAM;
            r.idx   = 2'(ch - 5'(STREAM_BASE));
            r.flags = ~hdr[2:1];
        end
        else if (ch >= 5'(ARQ_DATA_BASE) && ch < 5'(ARQ_DATA_BASE + NUM_ARQ))
        begin
            r.ok   = 1'b1;
            r.kind = DEST_ARQ_DATA;
            r.idx  = 2'(ch - 5'(ARQ_DATA_BASE));
        end
        else if (ch >= 5'(ARQ_ACK_BASE) && ch < 5'(ARQ_ACK_BASE + NUM_ARQ))
        begin
            r.ok   = 1'b1;
            r.kind = DEST_ARQ_ACK;
            r.idx  = 2'(ch - 5'(ARQ_ACK_BASE));
        end
        return r;
    endfunction

endpackage

### hw/rtl/mpfd_parser.sv
module mpfd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  mpfd_pkg::rx_item_t   item,
    output logic                 res_valid,
    output mpfd_pkg::frag_item_t res
);

    mpfd_pkg::phase_t phase_reg, phase_next;
    logic [8:0]       pdu_left_reg, pdu_left_next;
    logic [8:0]       frag_left_reg, frag_left_next;
    logic [7:0]       header_reg, header_next;
    logic             first_reg, first_next;
    logic             disc_reg, disc_next;

    mpfd_pkg::phase_t ph;
    logic [8:0]       pdu_cur;
    logic [8:0]       rem;
    logic [8:0]       frag_dec;
    logic             disc;
    logic [7:0]       hdr;
    mpfd_pkg::route_t rt;
    logic             emit;
    logic [7:0]       pbyte;
    logic             f_first, f_last, f_empty;

    always_comb
    begin
        phase_next     = phase_reg;
        pdu_left_next  = pdu_left_reg;
        frag_left_next = frag_left_reg;
        header_next    = header_reg;
        first_next     = first_reg;
        disc_next      = disc_reg;
        emit           = 1'b0;
        pbyte          = '0;
        f_first        = 1'b0;
        f_last         = 1'b0;
        f_empty        = 1'b0;
        frag_dec       = frag_left_reg;

        if (phase_reg == mpfd_pkg::PH_START)
        begin
            if (item.pdu_length == '0)
                pdu_cur = 9'd1;
            else if (item.pdu_length > 9'(mpfd_pkg::MAX_PDU_BYTES))
                pdu_cur = 9'(mpfd_pkg::MAX_PDU_BYTES);
            else
                pdu_cur = item.pdu_length;
            disc = 1'b0;
            ph   = mpfd_pkg::PH_HEADER;
        end
        else
        begin
            pdu_cur = (pdu_left_reg == '0) ? 9'd1 : pdu_left_reg;
            disc    = disc_reg;
            ph      = phase_reg;
        end
        rem = pdu_cur - 9'd1;
        hdr = (ph == mpfd_pkg::PH_HEADER) ? item.data_byte : header_reg;
        rt  = mpfd_pkg::route(hdr);

        if (fire)
        begin
            phase_next    = ph;
            disc_next     = disc;
            pdu_left_next = rem;
            if (!disc)
            begin
                unique case (ph)
                    mpfd_pkg::PH_HEADER:
                    begin
                        header_next = item.data_byte;
                        if (item.data_byte[0])
                        begin
                            if (rem != '0)
                                phase_next = mpfd_pkg::PH_LENGTH;
                        end
                        else if (rem == '0)
                        begin
                            emit    = 1'b1;
                            f_first = 1'b1;
                            f_last  = 1'b1;
                            f_empty = 1'b1;
                        end
                        else
                        begin
                            frag_left_next = rem;
                            first_next     = 1'b1;
                            phase_next     = mpfd_pkg::PH_PAYLOAD;
                        end
                    end
                    mpfd_pkg::PH_LENGTH:
                    begin
                        if ({1'b0, item.data_byte} > rem)
                            disc_next = 1'b1;
                        else if (item.data_byte == '0)
                        begin
                            emit       = 1'b1;
                            f_first    = 1'b1;
                            f_last     = 1'b1;
                            f_empty    = 1'b1;
                            phase_next = mpfd_pkg::PH_HEADER;
                        end
                        else
                        begin
                            frag_left_next = {1'b0, item.data_byte};
                            first_next     = 1'b1;
                            phase_next     = mpfd_pkg::PH_PAYLOAD;
                        end
                    end
                    mpfd_pkg::PH_PAYLOAD:
                    begin
                        emit       = 1'b1;
                        pbyte      = item.data_byte;
                        f_first    = first_reg;
                        f_last     = (frag_left_reg <= 9'd1);
                        first_next = 1'b0;
                        if (frag_left_reg != '0)
                            frag_dec = frag_left_reg - 9'd1;
                        frag_left_next = frag_dec;
                        if (frag_dec == '0)
                            phase_next = mpfd_pkg::PH_HEADER;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (rem == '0)
            begin
                phase_next     = mpfd_pkg::PH_START;
                disc_next      = 1'b0;
                frag_left_next = '0;
                first_next     = 1'b0;
            end
        end

        res_valid             = fire && emit && rt.ok;
        res.payload_byte      = pbyte;
        res.dest_kind         = rt.kind;
        res.channel_index     = rt.idx;
        res.seq_flags         = rt.flags;
        res.first_of_fragment = f_first;
        res.last_of_fragment  = f_last;
        res.empty_fragment    = f_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mpfd_pkg::PH_START;
            pdu_left_reg  <= '0;
            frag_left_reg <= '0;
            header_reg    <= '0;
            first_reg     <= 1'b0;
            disc_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pdu_left_reg  <= pdu_left_next;
            frag_left_reg <= frag_left_next;
            header_reg    <= header_next;
            first_reg     <= first_next;
            disc_reg      <= disc_next;
        end
    end

    a_pdu_end: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg != mpfd_pkg::PH_START && pdu_left_reg == 9'd1
        |=> phase_reg == mpfd_pkg::PH_START)
        else $error("pdu did not close after its last byte");

    a_open_pdu_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != mpfd_pkg::PH_START |-> pdu_left_reg != '0)
        else $error("open pdu with no bytes left");

    a_discard_phase: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> phase_reg == mpfd_pkg::PH_LENGTH)
        else $error("discard outside length phase");

    a_frag_fits: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == mpfd_pkg::PH_PAYLOAD
        |-> frag_left_reg != '0 && frag_left_reg <= pdu_left_reg)
        else $error("fragment count exceeds pdu");

    a_first_payload: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg |-> phase_reg == mpfd_pkg::PH_PAYLOAD)
        else $error("first flag pending outside payload");

endmodule

### hw/rtl/mpfd_out_reg.sv
module mpfd_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 load_valid,
    input  mpfd_pkg::frag_item_t load_item,
    output logic                 frag_valid,
    input  logic                 frag_ready,
    output mpfd_pkg::frag_item_t frag_item,
    output logic                 can_load
);

    logic                 valid_reg, valid_next;
    mpfd_pkg::frag_item_t item_reg;

    assign can_load   = !valid_reg || frag_ready;
    assign frag_valid = valid_reg;
    assign frag_item  = item_reg;

    always_comb
    begin
        if (load)
            valid_next = load_valid;
        else if (frag_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
            item_reg <= load_item;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load && load_valid |-> !valid_reg || frag_ready)
        else $error("pending request overwritten");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !frag_ready |=> valid_reg && $stable(item_reg))
        else $error("stalled request changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && item_reg.empty_fragment
        |-> item_reg.payload_byte == '0 && item_reg.first_of_fragment
            && item_reg.last_of_fragment)
        else $error("empty fragment request malformed");

endmodule

### hw/rtl/mux_pdu_fragment_demux.sv
// mux_pdu_fragment_demux: byte-serial receive demultiplexer for multiplexed link pdus
//
// rx channel (rx_valid/rx_ready/rx_item): one pdu byte per request; pdu_length
// is sampled only on the first byte of each pdu (zero as 1, saturated at 256)
// frag channel (frag_valid/frag_ready/frag_item): at most one request per rx
// byte, a tagged payload byte or an empty-fragment marker; bytes of channels
// that cannot be routed give none; headers and length bytes give only empty markers
// output: a result is registered and offered in the cycle after its byte is accepted
// throughput: one byte per cycle while the result register can load, set by the
// single parse stage feeding the result register
// stall: while frag_ready is low the pending request holds and rx_ready drops;
// rx_ready is high whenever the result register is empty or being drained
// reset: asynchronous, clears the parser to expect the start of a new pdu
// and empties the result register
module mux_pdu_fragment_demux (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    output logic                 rx_ready,
    input  mpfd_pkg::rx_item_t   rx_item,
    output logic                 frag_valid,
    input  logic                 frag_ready,
    output mpfd_pkg::frag_item_t frag_item
);

    logic                 fire;
    logic                 res_valid;
    mpfd_pkg::frag_item_t res;
    logic                 can_load;

    assign rx_ready = can_load;
    assign fire     = rx_valid && can_load;

    mpfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (rx_item),
        .res_valid (res_valid),
        .res       (res)
    );

    mpfd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .load_valid (res_valid),
        .load_item  (res),
        .frag_valid (frag_valid),
        .frag_ready (frag_ready),
        .frag_item  (frag_item),
        .can_load   (can_load)
    );

endmodule

### tb/mpfd_frag_checker.sv
module mpfd_frag_checker
    import mpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic       rx_ready,
    input  rx_item_t   rx_item,
    input  logic       frag_valid,
    input  logic       frag_ready,
    input  frag_item_t frag_item,
    output int         mismatch_count,
    output int         outstanding,
    output int         results_seen,
    output int         empty_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t     phase        = PH_START;
    logic [8:0] pdu_left     = '0;
    logic [8:0] frag_left    = '0;
    logic [7:0] frag_header  = '0;
    logic       first_due    = 1'b0;
    logic       skipping_pdu = 1'b0;

    frag_item_t expected_frags[$];

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
        results_seen   = 0;
        empty_seen     = 0;
    end

    // tag a fragment byte with its destination; unroutable channels give nothing
    task automatic queue_fragment_byte(input logic [7:0] pb, input logic first_flag,
                                       input logic last_flag, input logic empty_flag);
        frag_item_t item;
        int         ch;
        ch   = int'(frag_header[7:3]);
        item = '0;
        item.payload_byte      = pb;
        item.first_of_fragment = first_flag;
        item.last_of_fragment  = last_flag;
        item.empty_fragment    = empty_flag;
        if (ch >= STREAM_BASE && ch <= STREAM_LAST)
        begin
            item.dest_kind     = DEST_STREAM;
            item.channel_index = 2'(ch - STREAM_BASE);
            item.seq_flags     = ~frag_header[2:1];
            expected_frags.push_back(item);
        end
        else if (ch >= ARQ_DATA_BASE && ch < ARQ_DATA_BASE + NUM_ARQ)
        begin
            item.dest_kind     = DEST_ARQ_DATA;
            item.channel_index = 2'(ch - ARQ_DATA_BASE);
            expected_frags.push_back(item);
        end
        else if (ch >= ARQ_ACK_BASE && ch < ARQ_ACK_BASE + NUM_ARQ)
        begin
            item.dest_kind     = DEST_ARQ_ACK;
            item.channel_index = 2'(ch - ARQ_ACK_BASE);
            expected_frags.push_back(item);
        end
    endtask

    task automatic parse_pdu_byte(input rx_item_t req);
        logic [7:0] b;
        logic [8:0] n;
        b = req.data_byte;
        n = req.pdu_length;
        if (phase == PH_START)
        begin
            if (n == 9'd0)
                n = 9'd1;
            if (n > 9'(MAX_PDU_BYTES))
                n = 9'(MAX_PDU_BYTES);
            pdu_left     = n;
            skipping_pdu = 1'b0;
            phase        = PH_HEADER;
        end
        pdu_left = pdu_left - 9'd1;

        if (!skipping_pdu)
        begin
            case (phase)
                PH_HEADER:
                begin
                    frag_header = b;
                    if (b[0])
                    begin
                        if (pdu_left != 9'd0)
                            phase = PH_LENGTH;
                    end
                    else if (pdu_left == 9'd0)
                        queue_fragment_byte(8'h00, 1'b1, 1'b1, 1'b1);
                    else
                    begin
                        frag_left = pdu_left;
                        first_due = 1'b1;
                        phase     = PH_PAYLOAD;
                    end
                end
                PH_LENGTH:
                begin
                    if ({1'b0, b} > pdu_left)
                        skipping_pdu = 1'b1;
                    else if (b == 8'd0)
                    begin
                        queue_fragment_byte(8'h00, 1'b1, 1'b1, 1'b1);
                        phase = PH_HEADER;
                    end
                    else
                    begin
                        frag_left = {1'b0, b};
                        first_due = 1'b1;
                        phase     = PH_PAYLOAD;
                    end
                end
                default:
                begin
                    queue_fragment_byte(b, first_due, frag_left <= 9'd1, 1'b0);
                    first_due = 1'b0;
                    if (frag_left != 9'd0)
                        frag_left = frag_left - 9'd1;
                    if (frag_left == 9'd0)
                        phase = PH_HEADER;
                end
            endcase
        end

        // pdu end clears the phase, the skip flag and the fragment state
        if (pdu_left == 9'd0)
        begin
            phase        = PH_START;
            skipping_pdu = 1'b0;
            frag_left    = '0;
            first_due    = 1'b0;
        end
    endtask

    task automatic check_fragment(input frag_item_t got);
        frag_item_t want;
        results_seen++;
        if (got.empty_fragment)
            empty_seen++;
        if (expected_frags.size() == 0)
        begin
            $error("unexpected fragment request: %h", got);
            mismatch_count++;
            return;
        end
        want = expected_frags.pop_front();
        if (got.payload_byte !== want.payload_byte)
        begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
            mismatch_count++;
        end
        if (got.dest_kind !== want.dest_kind)
        begin
            $error("dest_kind: expected %0d, got %0d", want.dest_kind, got.dest_kind);
            mismatch_count++;
        end
        if (got.channel_index !== want.channel_index)
        begin
            $error("channel_index: expected %0d, got %0d",
                   want.channel_index, got.channel_index);
            mismatch_count++;
        end
        if (got.seq_flags !== want.seq_flags)
        begin
            $error("seq_flags: expected %0d, got %0d", want.seq_flags, got.seq_flags);
            mismatch_count++;
        end
        if (got.first_of_fragment !== want.first_of_fragment)
        begin
            $error("first_of_fragment: expected %0b, got %0b",
                   want.first_of_fragment, got.first_of_fragment);
            mismatch_count++;
        end
        if (got.last_of_fragment !== want.last_of_fragment)
        begin
            $error("last_of_fragment: expected %0b, got %0b",
                   want.last_of_fragment, got.last_of_fragment);
            mismatch_count++;
        end
        if (got.empty_fragment !== want.empty_fragment)
        begin
            $error("empty_fragment: expected %0b, got %0b",
                   want.empty_fragment, got.empty_fragment);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase        = PH_START;
            pdu_left     = '0;
            frag_left    = '0;
            frag_header  = '0;
            first_due    = 1'b0;
            skipping_pdu = 1'b0;
            expected_frags.delete();
            outstanding  = 0;
        end
        else
        begin
            if (frag_valid && frag_ready)
                check_fragment(frag_item);
            if (rx_valid && rx_ready)
                parse_pdu_byte(rx_item);
            outstanding = expected_frags.size();
        end
    end

endmodule

### tb/tb_mux_pdu_fragment_demux.sv
module tb_mux_pdu_fragment_demux;
    import mpfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_BYTES  = 950;
    localparam int HOLD_CYCLES   = 64;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       rx_valid   = 1'b0;
    logic       rx_ready;
    rx_item_t   rx_item    = '0;
    logic       frag_valid;
    logic       frag_ready = 1'b0;
    frag_item_t frag_item;

    int mismatch_count;
    int outstanding;
    int results_seen;
    int empty_seen;

    logic [7:0] pdu_bytes[$];
    bit         no_idle     = 1'b0;
    int         bytes_sent  = 0;
    int         pdus_sent   = 0;
    int         idle_cycles = 0;

    mux_pdu_fragment_demux u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_item    (rx_item),
        .frag_valid (frag_valid),
        .frag_ready (frag_ready),
        .frag_item  (frag_item)
    );

    mpfd_frag_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_valid),
        .rx_ready       (rx_ready),
        .rx_item        (rx_item),
        .frag_valid     (frag_valid),
        .frag_ready     (frag_ready),
        .frag_item      (frag_item),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .empty_seen     (empty_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (rx_valid && rx_ready) || (frag_valid && frag_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic [8:0] len_field);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            rx_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_item.data_byte  = b;
        rx_item.pdu_length = len_field;
        rx_valid           = 1'b1;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // pdu length rides on the first byte only, the rest carry noise
    task automatic send_pdu(input logic [8:0] len_field);
        for (int i = 0; i < pdu_bytes.size(); i++)
            send_byte(pdu_bytes[i], (i == 0) ? len_field : 9'($urandom_range(0, 511)));
        pdus_sent++;
    endtask

    task automatic wait_drained();
        rx_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic build_pdu(input int total, input bit noise);
        int         left;
        int         frag_len;
        int         pick;
        logic [4:0] ch;
        logic [7:0] hdr;
        pdu_bytes.delete();
        left = total;
        if (noise)
        begin
            repeat (total)
                pdu_bytes.push_back(8'($urandom_range(0, 255)));
            left = 0;
        end
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            ch   = (pick < 80) ? 5'($urandom_range(4, 15)) : 5'($urandom_range(0, 31));
            hdr  = {ch, 2'($urandom_range(0, 3)), 1'b0};
            pick = $urandom_range(0, 99);
            if (left == 1)
            begin
                hdr[0] = 1'($urandom_range(0, 1));
                pdu_bytes.push_back(hdr);
                left = 0;
            end
            else if (pick < 20)
            begin
                // fragment runs to pdu end
                pdu_bytes.push_back(hdr);
                repeat (left - 1)
                    pdu_bytes.push_back(8'($urandom_range(0, 255)));
                left = 0;
            end
            else
            begin
                hdr[0] = 1'b1;
                pdu_bytes.push_back(hdr);
                left--;
                if (pick < 25)
                begin
                    // length overruns the pdu
                    pdu_bytes.push_back(8'($urandom_range(left, 255)));
                    left--;
                    repeat (left)
                        pdu_bytes.push_back(8'($urandom_range(0, 255)));
                    left = 0;
                end
                else
                begin
                    frag_len = $urandom_range(0, (left - 1 < 12) ? left - 1 : 12);
                    pdu_bytes.push_back(8'(frag_len));
                    left--;
                    repeat (frag_len)
                        pdu_bytes.push_back(8'($urandom_range(0, 255)));
                    left -= frag_len;
                end
            end
        end
    endtask

    // receiver
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == 60 || taken == 400)
            begin
                frag_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                frag_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            frag_ready = 1'b1;
            @(posedge clk);
            while (!frag_valid)
                @(posedge clk);
            taken++;
            @(negedge clk);
        end
    end

    // sender
    initial
    begin
        int  total;
        int  pdu_idx;
        int  random_start;
        int  pick;
        logic [8:0] len_field;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty fragment without length byte, pdu length zero
        pdu_bytes = '{8'h20};
        send_pdu(9'd0);
        // length flag on the final byte
        pdu_bytes = '{8'h79};
        send_pdu(9'd1);
        // zero-length fragment, then ack channel running to pdu end
        pdu_bytes = '{8'h41, 8'h00, 8'h60, 8'hFF};
        send_pdu(9'd4);
        // unroutable channel
        pdu_bytes = '{8'h06, 8'hAA, 8'h55};
        send_pdu(9'd3);
        // length byte overruns the pdu
        pdu_bytes = '{8'h3F, 8'hFF, 8'h12, 8'h34};
        send_pdu(9'd4);
        // stream with flags, then empty ack fragment at pdu end
        pdu_bytes = '{8'h2B, 8'h02, 8'h80, 8'h01, 8'h7C};
        send_pdu(9'd5);
        pdu_bytes = '{8'h50, 8'h00};
        send_pdu(9'd2);
        pdu_bytes = '{8'h19, 8'h01, 8'h77};
        send_pdu(9'd3);
        wait_drained();

        pdu_idx      = 0;
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            pdu_idx++;
            no_idle = (pdu_idx % 12) < 2;
            pick    = $urandom_range(0, 99);
            if (pdu_idx == 40)
                total = MAX_PDU_BYTES;
            else if (pick < 85)
                total = $urandom_range(1, 16);
            else if (pick < 97)
                total = $urandom_range(17, 64);
            else
                total = $urandom_range(65, 160);
            if (total == 1 && $urandom_range(0, 1) == 1)
                len_field = 9'd0;
            else if (total == MAX_PDU_BYTES)
                len_field = 9'($urandom_range(MAX_PDU_BYTES, 511));
            else
                len_field = 9'(total);
            build_pdu(total, $urandom_range(0, 9) == 0);
            send_pdu(len_field);
            if (pdu_idx % 25 == 0)
                wait_drained();
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (8) @(negedge clk);

        $display("run: %0d pdu bytes in %0d pdus, %0d fragment requests checked (%0d empty)",
                 bytes_sent, pdus_sent, results_seen, empty_seen);
        if (mismatch_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
